@@ hdl/lsir_pkg.sv @@
package lsir_pkg;

   localparam int COORD_BITS    = 8;
   localparam int FRACTION_BITS = 16;
   localparam int COUNT_BITS    = 8;
   localparam int CSR_IDX_BITS  = 3;
   // write data as wide as the widest register
   localparam int CSR_DATA_BITS = (FRACTION_BITS > COORD_BITS) ? FRACTION_BITS : COORD_BITS;

   // threshold table: one entry per contact count, entry zero holds exactly one
   localparam int TBL_DEPTH  = 1 << COUNT_BITS;
   localparam int THR_BITS   = FRACTION_BITS + 1;
   localparam int PROD_BITS  = THR_BITS + FRACTION_BITS;
   // room for 4 * draw and 3 * prob
   localparam int SCALE_BITS = FRACTION_BITS + 2;

   localparam logic [THR_BITS-1:0] THR_ONE = THR_BITS'(1) << FRACTION_BITS;

   localparam logic [FRACTION_BITS-1:0] MOVE_PROB_RST   = FRACTION_BITS'(6236);
   localparam logic [FRACTION_BITS-1:0] INF_STAY_RST    = FRACTION_BITS'(65529);
   localparam logic [FRACTION_BITS-1:0] CONTACT_FAC_RST = FRACTION_BITS'(64884);
   localparam logic [COORD_BITS-1:0]    X_MAX_RST       = COORD_BITS'(50);
   localparam logic [COORD_BITS-1:0]    Y_MAX_RST       = COORD_BITS'(50);

   typedef enum logic [1:0] {
      HEALTH_SUSCEPTIBLE = 2'd0,
      HEALTH_INFECTED    = 2'd1,
      HEALTH_RECOVERED   = 2'd2
   } health_type;

   typedef enum logic [1:0] {
      TRANS_NONE   = 2'd0,
      TRANS_S_TO_I = 2'd1,
      TRANS_I_TO_R = 2'd2
   } trans_type;

   typedef enum logic [2:0] {
      DIR_STAY  = 3'd0,
      DIR_LEFT  = 3'd1,
      DIR_UP    = 3'd2,
      DIR_RIGHT = 3'd3,
      DIR_DOWN  = 3'd4
   } dir_type;

   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_MOVE_PROB   = 3'd0,
      CSR_INF_STAY    = 3'd1,
      CSR_CONTACT_FAC = 3'd2,
      CSR_X_MAX       = 3'd3,
      CSR_Y_MAX       = 3'd4
   } csr_idx_type;

   typedef struct packed {
      logic [1:0]               health;
      logic [COORD_BITS-1:0]    pos_x;
      logic [COORD_BITS-1:0]    pos_y;
      logic [COUNT_BITS-1:0]    infected_on_tile;
      logic [FRACTION_BITS-1:0] health_draw;
      logic [FRACTION_BITS-1:0] move_draw;
   } req_type;

   typedef struct packed {
      logic [1:0]            new_health;
      logic [COORD_BITS-1:0] new_x;
      logic [COORD_BITS-1:0] new_y;
      logic [1:0]            transition;
   } rsp_type;

endpackage

@@ hdl/lattice_sir_agent_step.sv @@
// A request accepted at a clock edge passes three register stages (1, 2, 3) and
// then gives its result on rsp_data with rsp_valid high. Throughput: one request
// per cycle while busy is low; the receiver cannot stall and is never waited on.
// Reset (synchronous, active high) and every write of the contact factor start a
// fill of the 256-entry contact threshold table, one entry per cycle through one
// multiplier; busy stays high during the fill. Other register writes take effect at once.
module lattice_sir_agent_step (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   start,
   output logic                                   busy,
   input  lsir_pkg::req_type                      req_data,
   output logic                                   rsp_valid,
   output lsir_pkg::rsp_type                      rsp_data,
   input  logic                                   csr_we,
   input  logic [lsir_pkg::CSR_IDX_BITS-1:0]      csr_index,
   input  logic [lsir_pkg::CSR_DATA_BITS-1:0]     csr_wdata
);

   localparam int FB = lsir_pkg::FRACTION_BITS;
   localparam int CB = lsir_pkg::COORD_BITS;
   localparam int NB = lsir_pkg::COUNT_BITS;
   localparam int TB = lsir_pkg::THR_BITS;
   localparam int PB = lsir_pkg::PROD_BITS;
   localparam int SB = lsir_pkg::SCALE_BITS;

   // configuration registers
   logic [FB-1:0] move_prob_ff;
   logic [FB-1:0] inf_stay_ff;
   logic [FB-1:0] contact_fac_ff;
   logic [CB-1:0] x_max_ff;
   logic [CB-1:0] y_max_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         move_prob_ff   <= lsir_pkg::MOVE_PROB_RST;
         inf_stay_ff    <= lsir_pkg::INF_STAY_RST;
         contact_fac_ff <= lsir_pkg::CONTACT_FAC_RST;
         x_max_ff       <= lsir_pkg::X_MAX_RST;
         y_max_ff       <= lsir_pkg::Y_MAX_RST;
      end else if (csr_we) begin
         case (csr_index)
            lsir_pkg::CSR_MOVE_PROB:   move_prob_ff   <= csr_wdata[FB-1:0];
            lsir_pkg::CSR_INF_STAY:    inf_stay_ff    <= csr_wdata[FB-1:0];
            lsir_pkg::CSR_CONTACT_FAC: contact_fac_ff <= csr_wdata[FB-1:0];
            lsir_pkg::CSR_X_MAX:       x_max_ff       <= csr_wdata[CB-1:0];
            lsir_pkg::CSR_Y_MAX:       y_max_ff       <= csr_wdata[CB-1:0];
            default: ;
         endcase
      end
   end

   // threshold table fill: entry k = factor^k with truncation after each product
   logic          fill_ff;
   logic [NB-1:0] fill_addr_ff;
   logic [TB-1:0] fill_thr_ff;
   logic [PB-1:0] fill_prod;
   logic          fill_restart;

   assign fill_restart = csr_we && (csr_index == lsir_pkg::CSR_CONTACT_FAC);
   assign fill_prod    = PB'(fill_thr_ff) * PB'(contact_fac_ff);

   always_ff @(posedge clock) begin
      if (reset || fill_restart) begin
         fill_ff      <= 1'b1;
         fill_addr_ff <= '0;
         fill_thr_ff  <= lsir_pkg::THR_ONE;
      end else if (fill_ff) begin
         fill_addr_ff <= fill_addr_ff + NB'(1);
         fill_thr_ff  <= fill_prod[FB +: TB];
         if (fill_addr_ff == {NB{1'b1}}) begin
            fill_ff <= 1'b0;
         end
      end
   end

   assign busy = fill_ff;

   logic [TB-1:0] thr_mem [lsir_pkg::TBL_DEPTH];
   logic [TB-1:0] s1_thr_ff;

   always_ff @(posedge clock) begin
      if (fill_ff) begin
         thr_mem[fill_addr_ff] <= fill_thr_ff;
      end
   end

   always_ff @(posedge clock) begin
      s1_thr_ff <= thr_mem[req_data.infected_on_tile];
   end

   // stage 1: capture request, clamp position onto the lattice
   logic              accept;
   logic              s1_valid_ff;
   lsir_pkg::req_type s1_req_ff;
   lsir_pkg::req_type s1_req_in;

   assign accept = start && !busy;

   always_comb begin
      s1_req_in = req_data;
      if (req_data.pos_x > x_max_ff) s1_req_in.pos_x = x_max_ff;
      if (req_data.pos_y > y_max_ff) s1_req_in.pos_y = y_max_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) s1_valid_ff <= 1'b0;
      else       s1_valid_ff <= accept;
   end

   always_ff @(posedge clock) begin
      s1_req_ff <= s1_req_in;
   end

   // stage 2: health decision and direction pick
   logic [SB-1:0] d1, d2, d3, d4, m1, m2, m3;

   assign d1 = SB'(s1_req_ff.move_draw);
   assign d2 = d1 << 1;
   assign d3 = d2 + d1;
   assign d4 = d1 << 2;
   assign m1 = SB'(move_prob_ff);
   assign m2 = m1 << 1;
   assign m3 = m2 + m1;

   function automatic lsir_pkg::dir_type pick2(
      input logic lt_a, input logic lt_b,
      input lsir_pkg::dir_type a, input lsir_pkg::dir_type b);
      lsir_pkg::dir_type r;
      if (lt_a)      r = a;
      else if (lt_b) r = b;
      else           r = lsir_pkg::DIR_STAY;
      return r;
   endfunction

   function automatic lsir_pkg::dir_type pick3(
      input logic lt_a, input logic lt_b, input logic lt_c,
      input lsir_pkg::dir_type a, input lsir_pkg::dir_type b,
      input lsir_pkg::dir_type c);
      lsir_pkg::dir_type r;
      if (lt_a)      r = a;
      else if (lt_b) r = b;
      else if (lt_c) r = c;
      else           r = lsir_pkg::DIR_STAY;
      return r;
   endfunction

   logic                  c3a, c3b, c21, c4a, c4c, c11;
   logic                  x_lo, x_hi, y_lo, y_hi;
   lsir_pkg::dir_type     s2_dir_in;
   lsir_pkg::health_type  s2_health_in;
   lsir_pkg::trans_type   s2_trans_in;

   assign c3a  = d3 < m1;
   assign c3b  = d3 < m2;
   assign c21  = d2 < m1;
   assign c4a  = d4 < m1;
   assign c4c  = d4 < m3;
   assign c11  = d1 < m1;
   assign x_lo = s1_req_ff.pos_x == '0;
   assign x_hi = s1_req_ff.pos_x == x_max_ff;
   assign y_lo = s1_req_ff.pos_y == '0;
   assign y_hi = s1_req_ff.pos_y == y_max_ff;

   // corners first, then walls, then bulk
   always_comb begin
      if (x_lo && y_lo)
         s2_dir_in = pick2(c21, c11, lsir_pkg::DIR_RIGHT, lsir_pkg::DIR_DOWN);
      else if (x_hi && y_lo)
         s2_dir_in = pick2(c21, c11, lsir_pkg::DIR_LEFT, lsir_pkg::DIR_DOWN);
      else if (x_lo && y_hi)
         s2_dir_in = pick2(c21, c11, lsir_pkg::DIR_RIGHT, lsir_pkg::DIR_UP);
      else if (x_hi && y_hi)
         s2_dir_in = pick2(c21, c11, lsir_pkg::DIR_LEFT, lsir_pkg::DIR_UP);
      else if (x_lo)
         s2_dir_in = pick3(c3a, c3b, c11, lsir_pkg::DIR_UP, lsir_pkg::DIR_RIGHT,
                           lsir_pkg::DIR_DOWN);
      else if (x_hi)
         s2_dir_in = pick3(c3a, c3b, c11, lsir_pkg::DIR_UP, lsir_pkg::DIR_LEFT,
                           lsir_pkg::DIR_DOWN);
      else if (y_lo)
         s2_dir_in = pick3(c3a, c3b, c11, lsir_pkg::DIR_LEFT, lsir_pkg::DIR_DOWN,
                           lsir_pkg::DIR_RIGHT);
      else if (y_hi)
         s2_dir_in = pick3(c3a, c3b, c11, lsir_pkg::DIR_LEFT, lsir_pkg::DIR_UP,
                           lsir_pkg::DIR_RIGHT);
      else if (c4a)
         s2_dir_in = lsir_pkg::DIR_LEFT;
      else if (c21)
         s2_dir_in = lsir_pkg::DIR_UP;
      else if (c4c)
         s2_dir_in = lsir_pkg::DIR_RIGHT;
      else if (c11)
         s2_dir_in = lsir_pkg::DIR_DOWN;
      else
         s2_dir_in = lsir_pkg::DIR_STAY;
   end

   // health: strict compares, so a draw on a threshold keeps the health
   always_comb begin
      s2_trans_in = lsir_pkg::TRANS_NONE;
      case (s1_req_ff.health)
         lsir_pkg::HEALTH_SUSCEPTIBLE: begin
            s2_health_in = lsir_pkg::HEALTH_SUSCEPTIBLE;
            if (TB'(s1_req_ff.health_draw) > s1_thr_ff) begin
               s2_health_in = lsir_pkg::HEALTH_INFECTED;
               s2_trans_in  = lsir_pkg::TRANS_S_TO_I;
            end
         end
         lsir_pkg::HEALTH_INFECTED: begin
            s2_health_in = lsir_pkg::HEALTH_INFECTED;
            if (s1_req_ff.health_draw > inf_stay_ff) begin
               s2_health_in = lsir_pkg::HEALTH_RECOVERED;
               s2_trans_in  = lsir_pkg::TRANS_I_TO_R;
            end
         end
         default: s2_health_in = lsir_pkg::HEALTH_RECOVERED;
      endcase
   end

   logic                 s2_valid_ff;
   lsir_pkg::dir_type    s2_dir_ff;
   lsir_pkg::health_type s2_health_ff;
   lsir_pkg::trans_type  s2_trans_ff;
   logic [CB-1:0]        s2_x_ff;
   logic [CB-1:0]        s2_y_ff;

   always_ff @(posedge clock) begin
      if (reset) s2_valid_ff <= 1'b0;
      else       s2_valid_ff <= s1_valid_ff;
   end

   always_ff @(posedge clock) begin
      s2_dir_ff    <= s2_dir_in;
      s2_health_ff <= s2_health_in;
      s2_trans_ff  <= s2_trans_in;
      s2_x_ff      <= s1_req_ff.pos_x;
      s2_y_ff      <= s1_req_ff.pos_y;
   end

   // stage 3: apply the step, staying on the lattice
   lsir_pkg::rsp_type rsp_in;
   lsir_pkg::rsp_type rsp_ff;
   logic              rsp_valid_ff;

   always_comb begin
      rsp_in.new_health = s2_health_ff;
      rsp_in.transition = s2_trans_ff;
      rsp_in.new_x      = s2_x_ff;
      rsp_in.new_y      = s2_y_ff;
      case (s2_dir_ff)
         lsir_pkg::DIR_LEFT:  if (s2_x_ff != '0)       rsp_in.new_x = s2_x_ff - CB'(1);
         lsir_pkg::DIR_RIGHT: if (s2_x_ff < x_max_ff)  rsp_in.new_x = s2_x_ff + CB'(1);
         lsir_pkg::DIR_UP:    if (s2_y_ff != '0)       rsp_in.new_y = s2_y_ff - CB'(1);
         lsir_pkg::DIR_DOWN:  if (s2_y_ff < y_max_ff)  rsp_in.new_y = s2_y_ff + CB'(1);
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else       rsp_valid_ff <= s2_valid_ff;
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

@@ dv/tb_top.sv @@
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 500000;
   localparam int MAX_REPORTS = 10;
   // health code with no meaning of its own, handled as recovered
   localparam logic [1:0] HEALTH_UNUSED = 2'd3;
   // register index that maps to nothing
   localparam logic [lsir_pkg::CSR_IDX_BITS-1:0] CSR_UNMAPPED = 3'd7;

   logic                               clock = 1'b0;
   logic                               reset = 1'b1;
   logic                               start = 1'b0;
   logic                               busy;
   lsir_pkg::req_type                  req_data = '0;
   logic                               rsp_valid;
   lsir_pkg::rsp_type                  rsp_data;
   logic                               csr_we = 1'b0;
   logic [lsir_pkg::CSR_IDX_BITS-1:0]  csr_index = '0;
   logic [lsir_pkg::CSR_DATA_BITS-1:0] csr_wdata = '0;

   // local copy of the register file
   logic [lsir_pkg::FRACTION_BITS-1:0] cfg_move_prob = lsir_pkg::MOVE_PROB_RST;
   logic [lsir_pkg::FRACTION_BITS-1:0] cfg_inf_stay  = lsir_pkg::INF_STAY_RST;
   logic [lsir_pkg::FRACTION_BITS-1:0] cfg_contact   = lsir_pkg::CONTACT_FAC_RST;
   logic [lsir_pkg::COORD_BITS-1:0]    cfg_x_max     = lsir_pkg::X_MAX_RST;
   logic [lsir_pkg::COORD_BITS-1:0]    cfg_y_max     = lsir_pkg::Y_MAX_RST;

   lsir_pkg::req_type agent_q[$];      // requests waiting to be driven
   lsir_pkg::rsp_type next_tick_q[$];  // predicted agent updates, oldest first
   int                idle_left = 0;
   int                steady_left = 0;
   int                fail_count = 0;
   int                cycle_count = 0;
   lsir_pkg::rsp_type want;

   lattice_sir_agent_step DUT (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // susceptible stay threshold: factor^count, truncated after each product
   function automatic logic [lsir_pkg::THR_BITS-1:0] contact_threshold(
      logic [lsir_pkg::COUNT_BITS-1:0] count);
      logic [lsir_pkg::PROD_BITS-1:0] t;
      int                             i;
      t = lsir_pkg::PROD_BITS'(lsir_pkg::THR_ONE);
      for (i = 0; i < int'(count); i++) begin
         if (t == 0) break;
         t = (t * cfg_contact) >> lsir_pkg::FRACTION_BITS;
      end
      return t[lsir_pkg::THR_BITS-1:0];
   endfunction

   function automatic lsir_pkg::dir_type pick_two(int unsigned d, lsir_pkg::dir_type a,
                                                  lsir_pkg::dir_type b);
      int unsigned m;
      m = cfg_move_prob;
      if (2 * d < m) return a;
      if (d < m) return b;
      return lsir_pkg::DIR_STAY;
   endfunction

   function automatic lsir_pkg::dir_type pick_three(int unsigned d, lsir_pkg::dir_type a,
                                                    lsir_pkg::dir_type b,
                                                    lsir_pkg::dir_type c);
      int unsigned m;
      m = cfg_move_prob;
      if (3 * d < m) return a;
      if (3 * d < 2 * m) return b;
      if (d < m) return c;
      return lsir_pkg::DIR_STAY;
   endfunction

   function automatic lsir_pkg::dir_type pick_four(int unsigned d);
      int unsigned m;
      m = cfg_move_prob;
      if (4 * d < m) return lsir_pkg::DIR_LEFT;
      if (2 * d < m) return lsir_pkg::DIR_UP;
      if (4 * d < 3 * m) return lsir_pkg::DIR_RIGHT;
      if (d < m) return lsir_pkg::DIR_DOWN;
      return lsir_pkg::DIR_STAY;
   endfunction

   // one tick of one agent: health transition, then one random-walk step
   function automatic lsir_pkg::rsp_type tick_agent(lsir_pkg::req_type a);
      lsir_pkg::rsp_type               res;
      logic [lsir_pkg::COORD_BITS-1:0] x;
      logic [lsir_pkg::COORD_BITS-1:0] y;
      int unsigned                     d;
      lsir_pkg::dir_type               dir;
      res = '0;
      res.transition = lsir_pkg::TRANS_NONE;
      case (a.health)
         lsir_pkg::HEALTH_SUSCEPTIBLE: begin
            res.new_health = lsir_pkg::HEALTH_SUSCEPTIBLE;
            if (a.health_draw > contact_threshold(a.infected_on_tile)) begin
               res.new_health = lsir_pkg::HEALTH_INFECTED;
               res.transition = lsir_pkg::TRANS_S_TO_I;
            end
         end
         lsir_pkg::HEALTH_INFECTED: begin
            res.new_health = lsir_pkg::HEALTH_INFECTED;
            if (a.health_draw > cfg_inf_stay) begin
               res.new_health = lsir_pkg::HEALTH_RECOVERED;
               res.transition = lsir_pkg::TRANS_I_TO_R;
            end
         end
         default: res.new_health = lsir_pkg::HEALTH_RECOVERED;
      endcase

      // off-lattice positions snap to the far walls
      x = (a.pos_x > cfg_x_max) ? cfg_x_max : a.pos_x;
      y = (a.pos_y > cfg_y_max) ? cfg_y_max : a.pos_y;
      d = a.move_draw;

      // corners first, then walls, then bulk
      if (x == 0 && y == 0)
         dir = pick_two(d, lsir_pkg::DIR_RIGHT, lsir_pkg::DIR_DOWN);
      else if (x == cfg_x_max && y == 0)
         dir = pick_two(d, lsir_pkg::DIR_LEFT, lsir_pkg::DIR_DOWN);
      else if (x == 0 && y == cfg_y_max)
         dir = pick_two(d, lsir_pkg::DIR_RIGHT, lsir_pkg::DIR_UP);
      else if (x == cfg_x_max && y == cfg_y_max)
         dir = pick_two(d, lsir_pkg::DIR_LEFT, lsir_pkg::DIR_UP);
      else if (x == 0)
         dir = pick_three(d, lsir_pkg::DIR_UP, lsir_pkg::DIR_RIGHT, lsir_pkg::DIR_DOWN);
      else if (x == cfg_x_max)
         dir = pick_three(d, lsir_pkg::DIR_UP, lsir_pkg::DIR_LEFT, lsir_pkg::DIR_DOWN);
      else if (y == 0)
         dir = pick_three(d, lsir_pkg::DIR_LEFT, lsir_pkg::DIR_DOWN, lsir_pkg::DIR_RIGHT);
      else if (y == cfg_y_max)
         dir = pick_three(d, lsir_pkg::DIR_LEFT, lsir_pkg::DIR_UP, lsir_pkg::DIR_RIGHT);
      else
         dir = pick_four(d);

      // a step off the lattice leaves that coordinate where it was
      case (dir)
         lsir_pkg::DIR_LEFT:  if (x > 0) x = x - 1'b1;
         lsir_pkg::DIR_RIGHT: if (x < cfg_x_max) x = x + 1'b1;
         lsir_pkg::DIR_UP:    if (y > 0) y = y - 1'b1;
         lsir_pkg::DIR_DOWN:  if (y < cfg_y_max) y = y + 1'b1;
         default: ;
      endcase
      res.new_x = x;
      res.new_y = y;
      return res;
   endfunction

   function automatic lsir_pkg::req_type mk_agent(logic [1:0] h, int x, int y, int c,
                                                  int hd, int md);
      lsir_pkg::req_type a;
      a.health           = h;
      a.pos_x            = lsir_pkg::COORD_BITS'(x);
      a.pos_y            = lsir_pkg::COORD_BITS'(y);
      a.infected_on_tile = lsir_pkg::COUNT_BITS'(c);
      a.health_draw      = lsir_pkg::FRACTION_BITS'(hd);
      a.move_draw        = lsir_pkg::FRACTION_BITS'(md);
      return a;
   endfunction

   // coordinates lean toward the walls, with some off the lattice
   function automatic logic [lsir_pkg::COORD_BITS-1:0] rand_coord(
      logic [lsir_pkg::COORD_BITS-1:0] lim);
      int r;
      r = $urandom_range(0, 99);
      if (r < 20) return '0;
      if (r < 40) return lim;
      if (r < 50 && lim != '1)
         return lsir_pkg::COORD_BITS'($urandom_range(int'(lim) + 1, 255));
      if (r < 55) return lsir_pkg::COORD_BITS'($urandom_range(0, 255));
      return lsir_pkg::COORD_BITS'($urandom_range(0, int'(lim)));
   endfunction

   function automatic lsir_pkg::req_type rand_agent();
      lsir_pkg::req_type a;
      int                r;
      int                cut;
      int                m;
      r = $urandom_range(0, 99);
      if (r < 40)      a.health = lsir_pkg::HEALTH_SUSCEPTIBLE;
      else if (r < 75) a.health = lsir_pkg::HEALTH_INFECTED;
      else if (r < 94) a.health = lsir_pkg::HEALTH_RECOVERED;
      else             a.health = HEALTH_UNUSED;
      a.pos_x = rand_coord(cfg_x_max);
      a.pos_y = rand_coord(cfg_y_max);

      r = $urandom_range(0, 99);
      if (r < 30)      a.infected_on_tile = lsir_pkg::COUNT_BITS'($urandom_range(0, 3));
      else if (r < 45) a.infected_on_tile = '1;
      else             a.infected_on_tile = lsir_pkg::COUNT_BITS'($urandom_range(0, 255));

      // health draw: near the relevant threshold, at the extremes, or anywhere
      if (a.health == lsir_pkg::HEALTH_SUSCEPTIBLE)
         cut = int'(contact_threshold(a.infected_on_tile));
      else
         cut = int'(cfg_inf_stay);
      r = $urandom_range(0, 99);
      if (r < 25) begin
         cut = cut + int'($urandom_range(0, 4)) - 2;
         if (cut < 0) cut = 0;
         if (cut > 65535) cut = 65535;
         a.health_draw = lsir_pkg::FRACTION_BITS'(cut);
      end else if (r < 35) begin
         a.health_draw = $urandom_range(0, 1) ? '1 : '0;
      end else begin
         a.health_draw = lsir_pkg::FRACTION_BITS'($urandom());
      end

      // move draw: mostly below move_prob, some right on a direction cut
      m = int'(cfg_move_prob);
      r = $urandom_range(0, 99);
      if (r < 60) begin
         a.move_draw = lsir_pkg::FRACTION_BITS'(
            $urandom_range(0, (m + 3 > 65535) ? 65535 : m + 3));
      end else if (r < 75) begin
         cut = (m * int'($urandom_range(0, 12))) / 12 + int'($urandom_range(0, 2)) - 1;
         if (cut < 0) cut = 0;
         if (cut > 65535) cut = 65535;
         a.move_draw = lsir_pkg::FRACTION_BITS'(cut);
      end else begin
         a.move_draw = lsir_pkg::FRACTION_BITS'($urandom());
      end
      return a;
   endfunction

   // idle gap after a request: mostly none or short, a few long, some steady runs
   function automatic int next_gap();
      int r;
      if (steady_left > 0) begin
         steady_left = steady_left - 1;
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 3) begin
         steady_left = $urandom_range(20, 80);
         return 0;
      end
      if (r < 50) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // append a request to the pending queue
   task automatic queue_agent(lsir_pkg::req_type a);
      agent_q.insert(agent_q.size(), a);
   endtask

   task automatic write_reg(logic [lsir_pkg::CSR_IDX_BITS-1:0] idx,
                            logic [lsir_pkg::CSR_DATA_BITS-1:0] value);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         lsir_pkg::CSR_MOVE_PROB:   cfg_move_prob = value;
         lsir_pkg::CSR_INF_STAY:    cfg_inf_stay  = value;
         lsir_pkg::CSR_CONTACT_FAC: cfg_contact   = value;
         lsir_pkg::CSR_X_MAX:       cfg_x_max     = value[lsir_pkg::COORD_BITS-1:0];
         lsir_pkg::CSR_Y_MAX:       cfg_y_max     = value[lsir_pkg::COORD_BITS-1:0];
         default: ;
      endcase
   endtask

   // narrow registers get junk in the upper data bits
   task automatic apply_setting(int mp, int inf, int fac, int xm, int ym);
      write_reg(lsir_pkg::CSR_MOVE_PROB, lsir_pkg::CSR_DATA_BITS'(mp));
      write_reg(lsir_pkg::CSR_INF_STAY, lsir_pkg::CSR_DATA_BITS'(inf));
      write_reg(lsir_pkg::CSR_CONTACT_FAC, lsir_pkg::CSR_DATA_BITS'(fac));
      write_reg(lsir_pkg::CSR_X_MAX, {8'($urandom()), 8'(xm)});
      write_reg(lsir_pkg::CSR_Y_MAX, {8'($urandom()), 8'(ym)});
      write_reg(CSR_UNMAPPED, lsir_pkg::CSR_DATA_BITS'($urandom()));
   endtask

   task automatic fill_random(int n);
      int i;
      @(negedge clock);
      for (i = 0; i < n; i++) queue_agent(rand_agent());
   endtask

   task automatic await_idle();
      while (agent_q.size() != 0 || start || busy || next_tick_q.size() != 0)
         @(negedge clock);
   endtask

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         start     <= 1'b0;
         idle_left <= 0;
      end else begin
         if (start && !busy) next_tick_q.insert(next_tick_q.size(), tick_agent(req_data));
         if (!start || !busy) begin
            if (idle_left > 0) begin
               start     <= 1'b0;
               idle_left <= idle_left - 1;
            end else if (agent_q.size() != 0) begin
               req_data  <= agent_q.pop_front();
               start     <= 1'b1;
               idle_left <= next_gap();
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   // result monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (next_tick_q.size() == 0) begin
            fail_count++;
            if (fail_count <= MAX_REPORTS)
               $display("unexpected result: health %0d x %0d y %0d trans %0d",
                        rsp_data.new_health, rsp_data.new_x, rsp_data.new_y,
                        rsp_data.transition);
         end else begin
            want = next_tick_q.pop_front();
            if (rsp_data.new_health !== want.new_health || rsp_data.new_x !== want.new_x ||
                rsp_data.new_y !== want.new_y || rsp_data.transition !== want.transition) begin
               fail_count++;
               if (fail_count <= MAX_REPORTS)
                  $display({"mismatch: expected h %0d x %0d y %0d t %0d, ",
                            "got h %0d x %0d y %0d t %0d"},
                           want.new_health, want.new_x, want.new_y, want.transition,
                           rsp_data.new_health, rsp_data.new_x, rsp_data.new_y,
                           rsp_data.transition);
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("tb_top failed");
         $finish;
      end
   end

   initial begin
      int p;
      int r;
      int mp;
      int inf;
      int fac;
      int xm;
      int ym;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed requests at reset settings (lattice 0..50, move_prob 6236)
      queue_agent(mk_agent(lsir_pkg::HEALTH_SUSCEPTIBLE, 0, 0, 0, 65535, 0));
      queue_agent(mk_agent(lsir_pkg::HEALTH_SUSCEPTIBLE, 50, 0, 255, 0, 3118));
      queue_agent(mk_agent(lsir_pkg::HEALTH_SUSCEPTIBLE, 0, 50, 1, 64884, 6235));
      queue_agent(mk_agent(lsir_pkg::HEALTH_SUSCEPTIBLE, 50, 50, 1, 64885, 6236));
      queue_agent(mk_agent(lsir_pkg::HEALTH_SUSCEPTIBLE, 25, 25, 255, 65535, 1558));
      queue_agent(mk_agent(lsir_pkg::HEALTH_SUSCEPTIBLE, 25, 25, 2, 32768, 1559));
      queue_agent(mk_agent(lsir_pkg::HEALTH_INFECTED, 0, 10, 0, 0, 2078));
      queue_agent(mk_agent(lsir_pkg::HEALTH_INFECTED, 0, 10, 7, 65529, 2079));
      queue_agent(mk_agent(lsir_pkg::HEALTH_INFECTED, 50, 10, 0, 65530, 4157));
      queue_agent(mk_agent(lsir_pkg::HEALTH_INFECTED, 10, 0, 0, 65535, 4158));
      queue_agent(mk_agent(lsir_pkg::HEALTH_RECOVERED, 10, 50, 0, 0, 0));
      queue_agent(mk_agent(lsir_pkg::HEALTH_RECOVERED, 25, 25, 255, 65535, 3117));
      queue_agent(mk_agent(HEALTH_UNUSED, 25, 25, 0, 65535, 3118));
      queue_agent(mk_agent(HEALTH_UNUSED, 255, 255, 255, 0, 0));
      queue_agent(mk_agent(lsir_pkg::HEALTH_SUSCEPTIBLE, 200, 10, 0, 100, 0));
      queue_agent(mk_agent(lsir_pkg::HEALTH_SUSCEPTIBLE, 10, 200, 0, 100, 65535));
      queue_agent(mk_agent(lsir_pkg::HEALTH_INFECTED, 25, 25, 0, 1, 4676));
      queue_agent(mk_agent(lsir_pkg::HEALTH_INFECTED, 25, 25, 0, 1, 4677));
      queue_agent(mk_agent(lsir_pkg::HEALTH_SUSCEPTIBLE, 1, 1, 128, 12345, 0));
      queue_agent(mk_agent(lsir_pkg::HEALTH_SUSCEPTIBLE, 49, 49, 255, 65535, 65535));
      queue_agent(mk_agent(lsir_pkg::HEALTH_RECOVERED, 0, 255, 0, 0, 1000));
      queue_agent(mk_agent(lsir_pkg::HEALTH_SUSCEPTIBLE, 255, 0, 3, 21845, 2000));
      fill_random(150);

      // fixed settings, extremes and degenerate lattices among them
      await_idle();
      apply_setting(65535, 0, 0, 255, 255);
      fill_random(150);
      await_idle();
      apply_setting(0, 65535, 65535, 1, 1);
      fill_random(100);
      await_idle();
      apply_setting(65535, 65535, 1, 0, 0);
      fill_random(60);
      await_idle();
      apply_setting(40000, 30000, 60000, 0, 7);
      fill_random(80);
      await_idle();
      apply_setting(50000, 100, 65000, 9, 0);
      fill_random(80);

      // random settings
      for (p = 0; p < 8; p++) begin
         await_idle();
         r = $urandom_range(0, 99);
         if (r < 15)      mp = 65535;
         else if (r < 30) mp = $urandom_range(0, 16);
         else             mp = $urandom_range(0, 65535);
         inf = ($urandom_range(0, 1) != 0) ? $urandom_range(60000, 65535)
                                            : $urandom_range(0, 65535);
         fac = ($urandom_range(0, 1) != 0) ? $urandom_range(60000, 65535)
                                            : $urandom_range(0, 65535);
         r = $urandom_range(0, 99);
         if (r < 50)      xm = $urandom_range(1, 8);
         else if (r < 85) xm = $urandom_range(1, 255);
         else             xm = 255;
         r = $urandom_range(0, 99);
         if (r < 50)      ym = $urandom_range(1, 8);
         else if (r < 85) ym = $urandom_range(1, 255);
         else             ym = 255;
         apply_setting(mp, inf, fac, xm, ym);
         fill_random(130);
      end

      // drain, then watch for stray results
      await_idle();
      repeat (10) @(negedge clock);
      if (fail_count == 0 && next_tick_q.size() == 0) begin
         $display("tb_top passed");
      end else begin
         $display("tb_top failed");
      end
      $finish;
   end

endmodule
